// ===== rtl/core/hofs_pkg.sv =====
// Package for heap_ordered_float_sum_core: sizes, defaults and double-precision helpers.
// Depends on nothing; used by the core, the adder and the checker.
package hofs_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int DW = 64;

	localparam logic [DW-1:0] QNAN_DEF = 64'hFFF8_0000_0000_0000;

	function automatic logic is_nan(input logic [DW-1:0] x);
		return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
	endfunction

	function automatic logic [DW-1:0] ord_key(input logic [DW-1:0] x);
		return x[63] ? ~x : {1'b1, x[62:0]};
	endfunction

	// ordered greater-than, false on NaN and on two zeros
	function automatic logic fp_gt(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic r;
		r = 1'b0;
		if (!is_nan(a) && !is_nan(b) && ((a[62:0] | b[62:0]) != 63'd0))
			r = ord_key(a) > ord_key(b);
		return r;
	endfunction

	// exact 2*x with overflow to infinity
	function automatic logic [DW-1:0] fp_dbl(input logic [DW-1:0] x);
		logic [DW-1:0] r;
		r = x;
		if (x[62:52] == 11'd0)
			r = {x[63], x[62:0] << 1};
		else if (x[62:52] == 11'h7FE)
			r = {x[63], 11'h7FF, 52'd0};
		else if (x[62:52] != 11'h7FF)
			r = {x[63], x[62:52] + 11'd1, x[51:0]};
		return r;
	endfunction

	function automatic logic beats(input logic [DW-1:0] c, input logic [DW-1:0] p);
		return fp_gt(c, p) && fp_gt(fp_dbl(c), p);
	endfunction

	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++)
			if (v[i]) n = 6'(55 - i);
		return n;
	endfunction

endpackage

// ===== rtl/core/heap_ordered_float_sum_core.sv =====
// Loads one double per beat, one beat per cycle while idle. For sets of three or more it
// then walks a heap in RAM (one read per cycle, sift steps S_SIFT/S_RD2/S_RD3, pipelined
// adder); every set ends in one sum. The walk time of larger sets is set by the single
// RAM read port. Inputs are refused during the walk. Reset (arst_n low) clears the
// count, the control state and out_valid; RAM contents and sum_bits are left as they are.
module heap_ordered_float_sum_core #(
	parameter int MAX_ITEMS = hofs_pkg::MAX_ITEMS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [hofs_pkg::DW-1:0] value_bits,
	input  logic                    last_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [hofs_pkg::DW-1:0] sum_bits
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int NW = CW + 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);

	localparam logic [4:0] S_IDLE = 5'd0, S_START = 5'd1, S_ONE = 5'd2, S_ONE2 = 5'd3,
		S_BUILD = 5'd4, S_BLD2 = 5'd5, S_BDEC = 5'd6, S_SIFT = 5'd7, S_RD2 = 5'd8,
		S_RD3 = 5'd9, S_LOOP = 5'd10, S_L2 = 5'd11, S_L3 = 5'd12, S_L4 = 5'd13,
		S_WAIT = 5'd14, S_L6 = 5'd15, S_L7 = 5'd16, S_FIN = 5'd17, S_F2 = 5'd18,
		S_F3 = 5'd19;

	logic [4:0]              state_q, ret_q;
	logic [CW-1:0]           cnt_q, size_q, k_q;
	logic [NW-1:0]           node_q, bi_q;
	logic [hofs_pkg::DW-1:0] cur_q, bv_q, h1_q, h2_q, sum_q;
	logic                    t3_q, fin_q, ov_q;

	logic                    we, fv, fgo, sec;
	logic [AW-1:0]           waddr, raddr;
	logic [hofs_pkg::DW-1:0] wdata, rdata, fa, fb, fsum;
	logic [NW-1:0]           kid, kid1, sz;

	assign kid  = {node_q[NW-2:0], 1'b0};
	assign kid1 = kid + NW'(1);
	assign sz   = {1'b0, size_q};
	assign sec  = (kid < sz) && hofs_pkg::beats(rdata, bv_q);

	function automatic logic [AW-1:0] adr(input logic [NW-1:0] i);
		logic [NW-1:0] j;
		j = i - NW'(1);
		return j[AW-1:0];
	endfunction

	hofs_ram #(.W(hofs_pkg::DW), .D(MAX_ITEMS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	hofs_fadd u_fadd (
		.clk(clk), .arst_n(arst_n), .in_v(fgo), .a(fa), .b(fb), .out_v(fv), .sum(fsum)
	);

	always_comb begin
		we    = 1'b0;
		waddr = adr(node_q);
		wdata = cur_q;
		raddr = adr(kid);
		fgo   = 1'b0;
		fa    = h1_q;
		fb    = rdata;
		case (state_q)
			S_IDLE: begin
				we    = in_valid && (cnt_q < MAXC);
				waddr = cnt_q[AW-1:0];
				wdata = value_bits;
			end
			S_ONE, S_FIN, S_LOOP: raddr = adr(NW'(1));
			S_BUILD: raddr = adr({1'b0, k_q});
			S_SIFT: we = kid > sz;
			S_RD2: raddr = adr(kid1);
			S_RD3: begin
				we    = 1'b1;
				wdata = (sec || bi_q != node_q) ? (sec ? rdata : bv_q) : cur_q;
			end
			S_L2, S_F2: raddr = adr(NW'(2));
			S_L3: raddr = adr(NW'(3));
			S_L4: begin
				fgo = 1'b1;
				fa  = hofs_pkg::fp_gt(rdata, h2_q) ? h2_q : rdata;
				fb  = h1_q;
			end
			S_F3: fgo = 1'b1;
			S_L6: raddr = adr(sz);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_ONE2: sum_q <= rdata;
			S_BLD2, S_L7: cur_q <= rdata;
			S_RD2: begin
				if (hofs_pkg::beats(rdata, cur_q)) begin
					bv_q <= rdata;
					bi_q <= kid;
				end else begin
					bv_q <= cur_q;
					bi_q <= node_q;
				end
			end
			S_L2, S_F2: h1_q <= rdata;
			S_L3: h2_q <= rdata;
			S_L4: t3_q <= !hofs_pkg::fp_gt(rdata, h2_q);
			S_WAIT: begin
				if (fin_q) sum_q <= fsum;
				else cur_q <= fsum;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			cnt_q   <= '0;
			size_q  <= '0;
			k_q     <= '0;
			node_q  <= '0;
			fin_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					if (last_item) begin
						size_q  <= (cnt_q < MAXC) ? cnt_q + CW'(1) : cnt_q;
						cnt_q   <= '0;
						state_q <= S_START;
					end else if (cnt_q < MAXC) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_START: begin
					if (size_q == CW'(1)) state_q <= S_ONE;
					else if (size_q == CW'(2)) state_q <= S_FIN;
					else begin
						k_q     <= size_q >> 1;
						state_q <= S_BUILD;
					end
				end
				S_ONE: if (!ov_q) state_q <= S_ONE2;
				S_ONE2: begin
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_BUILD: state_q <= (k_q == '0) ? S_LOOP : S_BLD2;
				S_BLD2: begin
					node_q  <= {1'b0, k_q};
					ret_q   <= S_BDEC;
					state_q <= S_SIFT;
				end
				S_BDEC: begin
					k_q     <= k_q - CW'(1);
					state_q <= S_BUILD;
				end
				S_SIFT: state_q <= (kid > sz) ? ret_q : S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: begin
					if (!sec && bi_q == node_q) state_q <= ret_q;
					else begin
						node_q  <= sec ? kid1 : bi_q;
						state_q <= S_SIFT;
					end
				end
				S_LOOP: state_q <= (size_q == CW'(2)) ? S_FIN : S_L2;
				S_L2: state_q <= S_L3;
				S_L3: state_q <= S_L4;
				S_L4: begin
					fin_q   <= 1'b0;
					state_q <= S_WAIT;
				end
				S_WAIT: if (fv) begin
					if (fin_q) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						node_q  <= t3_q ? NW'(3) : NW'(2);
						ret_q   <= S_L6;
						state_q <= S_SIFT;
					end
				end
				S_L6: state_q <= S_L7;
				S_L7: begin
					size_q  <= size_q - CW'(1);
					node_q  <= NW'(1);
					ret_q   <= S_LOOP;
					state_q <= S_SIFT;
				end
				S_FIN: if (!ov_q) state_q <= S_F2;
				S_F2: state_q <= S_F3;
				S_F3: begin
					fin_q   <= 1'b1;
					state_q <= S_WAIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ov_q;
	assign sum_bits  = sum_q;
endmodule

// ===== rtl/core/hofs_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// Depends on nothing.
module hofs_ram #(
	parameter int W = 64,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/hofs_fadd.sv =====
// Four-stage pipelined IEEE double adder, round to nearest even.
// Depends on hofs_pkg.
module hofs_fadd (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_v,
	input  logic [hofs_pkg::DW-1:0] a,
	input  logic [hofs_pkg::DW-1:0] b,
	output logic                    out_v,
	output logic [hofs_pkg::DW-1:0] sum
);
	// stage 1: unpack, order by magnitude, specials
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    sg_s1, sub_s1, zs_s1, sp_s1;
	logic [hofs_pkg::DW-1:0] spv_s1;
	logic [10:0]             e_s1, d_s1;
	logic [52:0]             mb_s1, ms_s1;

	logic                    a_big, na, nb, ia, ib;
	logic [hofs_pkg::DW-1:0] bg, sm, spv;
	logic [10:0]             eb, es;

	always_comb begin
		na = hofs_pkg::is_nan(a);
		nb = hofs_pkg::is_nan(b);
		ia = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
		ib = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
		a_big = a[62:0] >= b[62:0];
		bg = a_big ? a : b;
		sm = a_big ? b : a;
		eb = (bg[62:52] == 11'd0) ? 11'd1 : bg[62:52];
		es = (sm[62:52] == 11'd0) ? 11'd1 : sm[62:52];
		if (na) spv = a | (64'd1 << 51);
		else if (nb) spv = b | (64'd1 << 51);
		else if (ia && ib && (a[63] != b[63])) spv = hofs_pkg::QNAN_DEF;
		else if (ia) spv = a;
		else spv = b;
	end

	always_ff @(posedge clk) begin
		sg_s1  <= bg[63];
		sub_s1 <= a[63] ^ b[63];
		zs_s1  <= a[63] & b[63];
		sp_s1  <= na | nb | ia | ib;
		spv_s1 <= spv;
		e_s1   <= eb;
		d_s1   <= eb - es;
		mb_s1  <= {bg[62:52] != 11'd0, bg[51:0]};
		ms_s1  <= {sm[62:52] != 11'd0, sm[51:0]};
	end

	// stage 2: align and add
	logic                    sg_s2, zs_s2, sp_s2;
	logic [hofs_pkg::DW-1:0] spv_s2;
	logic [11:0]             e_s2;
	logic [56:0]             sum_s2;
	logic [55:0]             ms_x, al, lost;

	always_comb begin
		ms_x = {ms_s1, 3'b000};
		lost = ms_x & ~({56{1'b1}} << d_s1[5:0]);
		if (d_s1 >= 11'd56) al = {55'd0, |ms_x};
		else al = (ms_x >> d_s1[5:0]) | {55'd0, |lost};
	end

	always_ff @(posedge clk) begin
		sg_s2  <= sg_s1;
		zs_s2  <= zs_s1;
		sp_s2  <= sp_s1;
		spv_s2 <= spv_s1;
		e_s2   <= {1'b0, e_s1};
		sum_s2 <= sub_s1 ? ({1'b0, mb_s1, 3'b000} - {1'b0, al})
			: ({1'b0, mb_s1, 3'b000} + {1'b0, al});
	end

	// stage 3: normalize
	logic                    sg_s3, zs_s3, sp_s3, z_s3;
	logic [hofs_pkg::DW-1:0] spv_s3;
	logic [11:0]             e_s3, lim;
	logic [55:0]             m_s3;
	logic [5:0]              lz, sh;

	always_comb begin
		lz  = hofs_pkg::lzc56(sum_s2[55:0]);
		lim = e_s2 - 12'd1;
		sh  = ({6'd0, lz} < lim) ? lz : lim[5:0];
	end

	always_ff @(posedge clk) begin
		sg_s3  <= sg_s2;
		zs_s3  <= zs_s2;
		sp_s3  <= sp_s2;
		spv_s3 <= spv_s2;
		z_s3   <= sum_s2 == 57'd0;
		if (sum_s2[56]) begin
			m_s3 <= {sum_s2[56:2], sum_s2[1] | sum_s2[0]};
			e_s3 <= e_s2 + 12'd1;
		end else begin
			m_s3 <= sum_s2[55:0] << sh;
			e_s3 <= e_s2 - {6'd0, sh};
		end
	end

	// stage 4: round and pack
	logic [11:0]             ef;
	logic [63:0]             base, rnd;
	logic                    up;
	logic [hofs_pkg::DW-1:0] res;

	always_comb begin
		ef   = m_s3[55] ? e_s3 : 12'd0;
		base = {ef, m_s3[54:3]};
		up   = m_s3[2] & (m_s3[1] | m_s3[0] | m_s3[3]);
		rnd  = base + {63'd0, up};
		if (sp_s3) res = spv_s3;
		else if (z_s3) res = {zs_s3, 63'd0};
		else if (rnd[63:52] >= 12'h7FF) res = {sg_s3, 11'h7FF, 52'd0};
		else res = {sg_s3, rnd[62:0]};
	end

	always_ff @(posedge clk) sum <= res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_v = v_s4;
endmodule

// ===== rtl/core/hofs_chk.sv =====
// Port-level checker for heap_ordered_float_sum_core, bound to the top level.
// Depends on hofs_pkg.
module hofs_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    last_item,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [hofs_pkg::DW-1:0] sum_bits
);
	// one result may wait while the next set is being walked
	logic [1:0] pend_q;
	logic       take, give;

	assign take = in_valid && in_ready && last_item;
	assign give = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 2'd0;
		else if (take && !give) pend_q <= pend_q + 2'd1;
		else if (give && !take) pend_q <= pend_q - 2'd1;
	end

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0) else $error("result without a closing beat");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_item |=> !in_ready) else $error("input taken during walk");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("result repeated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_bits)) else $error("result dropped");
endmodule

bind heap_ordered_float_sum_core hofs_chk u_hofs_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.last_item(last_item), .out_valid(out_valid), .out_ready(out_ready), .sum_bits(sum_bits)
);
